@@ rtl/hdcl_pkg.sv @@
// Shared constants, types and codes for the code-length Huffman decoder.
`timescale 1ns / 1ps
package hdcl_pkg;

  localparam int MAX_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 32;

  localparam int SYM_W   = 8;
  localparam int LEN_W   = 6;
  localparam int CODE_W  = 33;
  localparam int ACC_W   = MAX_CODE_LEN;
  localparam int COUNT_W = $clog2(MAX_SYMBOLS + 1);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_DECODE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_PUSH,
    ST_CAPTURE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } scan_t;

  typedef struct packed {
    logic push;
    logic capture;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ rtl/huffman_decoder_from_code_lengths.sv @@
// Huffman decoder from code lengths: request sequencer, code builder and cell row.
// Path from accept to result beat: clear, unused type, overflow and load to a full table
// go straight to emit; load passes align and push; decode passes capture and the scan.
// One request at a time: a new one is taken only in idle. The decode scan moves one cell
// a cycle along the cell row, newest entry first, and stops at the first hit or the last entry.
// Reset: synchronous; clears count, running code, accumulator and handshake state.
// Table cells are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module huffman_decoder_from_code_lengths (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // entry_symbol[7:0], entry_length[13:8], bit_in[14], zeros
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // symbol[7:0]
  output logic [1:0]  m_tuser   // symbol_valid[0], overflow_error[1]
);
  import hdcl_pkg::*;

  state_t            state, state_next;
  cell_ctrl_t        ctrl;
  scan_t             head;
  entry_t            new_entry;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] remaining;
  logic [CODE_W-1:0]  build_code;
  logic [LEN_W-1:0]   build_length;
  logic [ACC_W-1:0]   acc_code;
  logic [LEN_W-1:0]   acc_len;
  logic [SYM_W-1:0]   pend_sym;
  logic [LEN_W-1:0]   pend_len;
  logic               res_valid;
  logic [SYM_W-1:0]   res_sym;
  logic               res_ovf;

  logic               accept;
  logic               out_load;
  req_t               req;
  logic [LEN_W-1:0]   shift_d;
  logic [CODE_W-1:0]  aligned;
  logic [CODE_W-1:0]  code_inc;

  assign accept = s_tvalid && s_tready;
  assign req    = req_t'(s_tuser);

  // Align the running code to the pending entry's length.
  always_comb begin
    shift_d = '0;
    aligned = build_code;
    if (pend_len > build_length) begin
      shift_d = pend_len - build_length;
      aligned = (shift_d >= LEN_W'(CODE_W)) ? '0 : (build_code << shift_d);
    end else if (pend_len < build_length) begin
      shift_d = build_length - pend_len;
      aligned = (shift_d >= LEN_W'(CODE_W)) ? '0 : (build_code >> shift_d);
    end
  end

  assign code_inc  = build_code + CODE_W'(1);
  assign new_entry = '{sym: pend_sym, len: build_length, code: build_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          case (req)
            REQ_LOAD: begin
              state_next = (count < COUNT_W'(MAX_SYMBOLS)) ? ST_ALIGN : ST_EMIT;
            end
            REQ_DECODE: begin
              state_next = (acc_len >= LEN_W'(MAX_CODE_LEN)) ? ST_EMIT : ST_CAPTURE;
            end
            default: begin
              state_next = ST_EMIT;
            end
          endcase
        end
      end
      ST_ALIGN: begin
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        ctrl.push  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_CAPTURE: begin
        ctrl.capture = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        if (remaining == '0 || head.hit) begin
          state_next = ST_EMIT;
        end else begin
          ctrl.shift = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      build_code   <= '0;
      build_length <= '0;
      acc_code     <= '0;
      acc_len      <= '0;
      remaining    <= '0;
    end else begin
      if (accept) begin
        case (req)
          REQ_CLEAR: begin
            count        <= '0;
            build_code   <= '0;
            build_length <= '0;
            acc_code     <= '0;
            acc_len      <= '0;
          end
          REQ_DECODE: begin
            if (acc_len >= LEN_W'(MAX_CODE_LEN)) begin
              acc_code <= '0;
              acc_len  <= '0;
            end else begin
              acc_code <= {acc_code[ACC_W-2:0], s_tdata[14]};
              acc_len  <= acc_len + LEN_W'(1);
            end
            remaining <= count;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_ALIGN) begin
        build_code   <= aligned;
        build_length <= pend_len;
      end
      if (state == ST_PUSH) begin
        build_code <= code_inc;
        // grow the length when the increment carries out of it
        if (build_length < LEN_W'(CODE_W) && code_inc == (CODE_W'(1) << build_length)) begin
          build_length <= build_length + LEN_W'(1);
        end
        count <= count + COUNT_W'(1);
      end
      if (state == ST_SCAN) begin
        if (remaining != '0 && head.hit) begin
          acc_code <= '0;
          acc_len  <= '0;
        end else if (remaining != '0) begin
          remaining <= remaining - COUNT_W'(1);
        end
      end
    end
  end

  // Pending result and latched entry: payload only.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_sym  <= s_tdata[7:0];
      pend_len  <= s_tdata[13:8];
      res_valid <= 1'b0;
      res_sym   <= '0;
      res_ovf   <= (req == REQ_DECODE) && (acc_len >= LEN_W'(MAX_CODE_LEN));
    end
    if (state == ST_SCAN && remaining != '0 && head.hit) begin
      res_valid <= 1'b1;
      res_sym   <= head.sym;
    end
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_sym;
      m_tuser <= {res_ovf, res_valid};
    end
  end

  hdcl_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .new_entry (new_entry),
    .count     (count),
    .acc_code  (acc_code),
    .acc_len   (acc_len),
    .head      (head)
  );

endmodule

@@ rtl/hdcl_cell.sv @@
// One table cell: a stored entry, its match compare and one stage of the scan line.
`timescale 1ns / 1ps
module hdcl_cell (
  input  logic                            clk,
  input  hdcl_pkg::cell_ctrl_t            ctrl,
  input  hdcl_pkg::entry_t                entry_in,
  output hdcl_pkg::entry_t                entry_out,
  input  logic                            active,
  input  logic [hdcl_pkg::ACC_W-1:0]      acc_code,
  input  logic [hdcl_pkg::LEN_W-1:0]      acc_len,
  input  hdcl_pkg::scan_t                 scan_in,
  output hdcl_pkg::scan_t                 scan_out
);
  import hdcl_pkg::*;

  entry_t entry;
  scan_t  scan;
  logic   match;

  assign match = active && (entry.len == acc_len)
                 && (entry.code == {{(CODE_W-ACC_W){1'b0}}, acc_code});

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= entry_in;
    end
    if (ctrl.capture) begin
      scan.hit <= match;
      scan.sym <= entry.sym;
    end else if (ctrl.shift) begin
      scan <= scan_in;
    end
  end

  assign entry_out = entry;
  assign scan_out  = scan;

endmodule

@@ rtl/hdcl_chain.sv @@
// Row of table cells: newest entry at the head, scan tokens move towards the head.
`timescale 1ns / 1ps
module hdcl_chain (
  input  logic                            clk,
  input  hdcl_pkg::cell_ctrl_t            ctrl,
  input  hdcl_pkg::entry_t                new_entry,
  input  logic [hdcl_pkg::COUNT_W-1:0]    count,
  input  logic [hdcl_pkg::ACC_W-1:0]      acc_code,
  input  logic [hdcl_pkg::LEN_W-1:0]      acc_len,
  output hdcl_pkg::scan_t                 head
);
  import hdcl_pkg::*;

  entry_t entries [MAX_SYMBOLS];
  scan_t  scans   [MAX_SYMBOLS];

  for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_cell
    entry_t ein;
    scan_t  sin;

    if (k == 0) begin : g_head
      assign ein = new_entry;
    end else begin : g_body
      assign ein = entries[k-1];
    end

    if (k == MAX_SYMBOLS - 1) begin : g_tail
      assign sin = '0;
    end else begin : g_link
      assign sin = scans[k+1];
    end

    hdcl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .entry_in  (ein),
      .entry_out (entries[k]),
      .active    (count > COUNT_W'(k)),
      .acc_code  (acc_code),
      .acc_len   (acc_len),
      .scan_in   (sin),
      .scan_out  (scans[k])
    );
  end

  assign head = scans[0];

endmodule
